FILE: rtl/sorted_keyed_snapshot_table_defines.svh
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_KEYED_SNAPSHOT_TABLE_DEFINES_SVH
`define SORTED_KEYED_SNAPSHOT_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SKST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SKST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/skst_pkg.sv
package skst_pkg;

    // Fixed field widths of the ports
    localparam int KEY_WIDTH        = 32;
    localparam int DATA_PORT_WIDTH  = 64;
    localparam int COUNT_PORT_WIDTH = 5;
    localparam int CFG_WIDTH        = 5;

    // Reset value of the entry limit register
    localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 5'd16;

    // Operation codes on func
    localparam logic FUNC_SAVE   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD,   // keep contents
        CMD_INS,    // insert at sorted slot, shift larger entries up
        CMD_INSF,   // insert into a full row, shift smaller entries down
        CMD_OVR,    // overwrite payload of the matching entry
        CMD_SHIFT   // drop the smallest entry, shift all down by one
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      occupied;
    } cell_ctrl_t;

    typedef struct packed {
        logic lt;   // held key below the item key
        logic eq;   // held key equals the item key
    } cell_stat_t;

endpackage

FILE: rtl/sorted_keyed_snapshot_table.sv
// Sorted snapshot table: keeps up to DEPTH (frame_key, payload) entries in
// ascending key order in a row of cells, each cell holding one entry.
// Input beat (in_valid / in_stall): func selects save or lookup, frame_key is
// the key, payload is stored on save. Output beat (out_valid / out_stall):
// hit, read_payload and entry_count, exactly one beat per input beat, in order.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_data sets the
// entry limit; write it only while no item is in flight.
// Steps: an item is taken in ST_IDLE, the cells compare the key in ST_CMP,
// the row updates in ST_UPD, and in ST_EVICT the row first shifts down once
// for each slot a save must evict to get down to the limit (a full-row insert
// drops its smallest entry within the update itself), then the result is
// loaded into the output register and out_valid rises. Lookups never evict.
// One item is in flight at a time; in_stall is high while busy.
// A finished result waits in the output register while out_stall is high and
// the next item is accepted meanwhile; it is only held back from finishing
// until the output register frees.
// Reset empties the table (entry count zero), sets the limit to 16 and clears
// the output register. Entry contents are not cleared.
module sorted_keyed_snapshot_table
    import skst_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [KEY_WIDTH-1:0]        frame_key,
    input  logic [DATA_PORT_WIDTH-1:0]  payload,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic [DATA_PORT_WIDTH-1:0]  read_payload,
    output logic [COUNT_PORT_WIDTH-1:0] entry_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_WIDTH-1:0]        cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > COUNT_PORT_WIDTH) ? CW : COUNT_PORT_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_EVICT
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               count_reg;
    logic [CFG_WIDTH-1:0]        limit_reg;
    logic                        func_reg;
    logic [KEY_WIDTH-1:0]        key_reg;
    logic [PAYLOAD_WIDTH-1:0]    pay_reg;
    logic                        res_hit_reg;
    logic [PAYLOAD_WIDTH-1:0]    res_pay_reg;
    logic                        out_valid_reg;
    logic                        hit_reg;
    logic [DATA_PORT_WIDTH-1:0]  read_payload_reg;
    logic [COUNT_PORT_WIDTH-1:0] entry_count_reg;

    logic [KEY_WIDTH-1:0]        cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]    cell_pay [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]    cell_sel [DEPTH];
    cell_stat_t                  cell_stat [DEPTH];
    cell_ctrl_t                  cell_ctrl [DEPTH];
    logic [DEPTH-1:0]            lt_vec;
    logic [DEPTH-1:0]            eq_vec;

    logic                        hit_any;
    logic [PAYLOAD_WIDTH-1:0]    hit_pay;
    cell_cmd_t                   upd_cmd;
    cell_cmd_t                   cmd;
    logic [LW-1:0]               count_ext;
    logic [LW-1:0]               limit_ext;
    logic [LW-1:0]               depth_ext;
    logic [LW-1:0]               eff_limit;
    logic                        over;
    logic                        out_free;
    logic                        load_out;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_EVICT) && !over && out_free;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg <= func;
            key_reg  <= frame_key;
            pay_reg  <= payload[PAYLOAD_WIDTH-1:0];
        end
    end

    // Hold the entry limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Saturate the limit at DEPTH and test a save for overflow
    always_comb
    begin
        count_ext = LW'(count_reg);
        limit_ext = LW'(limit_reg);
        depth_ext = LW'(DEPTH);
        eff_limit = (limit_ext > depth_ext) ? depth_ext : limit_ext;
        over      = (func_reg == FUNC_SAVE) && (count_ext > eff_limit);
    end

    // Gather compare flags and the one-hot hit payload
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            lt_vec[i] = cell_stat[i].lt;
            eq_vec[i] = cell_stat[i].eq;
        end
        hit_any = |eq_vec;
        hit_pay = '0;
        for (int i = 0; i < DEPTH; i++)
            hit_pay = hit_pay | cell_sel[i];
    end

    // Decide the row command
    always_comb
    begin
        upd_cmd = CMD_HOLD;
        if (func_reg == FUNC_SAVE)
        begin
            if (hit_any)
                upd_cmd = CMD_OVR;
            else if (count_reg == CW'(DEPTH))
                upd_cmd = CMD_INSF;
            else
                upd_cmd = CMD_INS;
        end
        case (state_reg)
            ST_UPD:   cmd = upd_cmd;
            ST_EVICT: cmd = over ? CMD_SHIFT : CMD_HOLD;
            default:  cmd = CMD_HOLD;
        endcase
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]     key_below;
        logic [PAYLOAD_WIDTH-1:0] pay_below;
        logic                     lt_below;
        logic [KEY_WIDTH-1:0]     key_above;
        logic [PAYLOAD_WIDTH-1:0] pay_above;
        logic                     lt_above;

        if (i == 0)
        begin : g_bot
            assign key_below = '0;
            assign pay_below = '0;
            assign lt_below  = 1'b1;
        end
        else
        begin : g_mid_lo
            assign key_below = cell_key[i-1];
            assign pay_below = cell_pay[i-1];
            assign lt_below  = lt_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign key_above = '0;
            assign pay_above = '0;
            assign lt_above  = 1'b0;
        end
        else
        begin : g_mid_hi
            assign key_above = cell_key[i+1];
            assign pay_above = cell_pay[i+1];
            assign lt_above  = lt_vec[i+1];
        end

        assign cell_ctrl[i].cmd      = cmd;
        assign cell_ctrl[i].occupied = (CW'(i) < count_reg);

        skst_cell #(
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .key_cmp   (key_reg),
            .pay_new   (pay_reg),
            .key_below (key_below),
            .pay_below (pay_below),
            .lt_below  (lt_below),
            .key_above (key_above),
            .pay_above (pay_above),
            .lt_above  (lt_above),
            .key_out   (cell_key[i]),
            .pay_out   (cell_pay[i]),
            .stat      (cell_stat[i]),
            .sel_pay   (cell_sel[i])
        );
    end

    // Sequence compare, update, eviction and result load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            res_hit_reg      <= 1'b0;
            res_pay_reg      <= '0;
            out_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            read_payload_reg <= '0;
            entry_count_reg  <= '0;
        end
        else
        begin
            // Raise valid on a new result, otherwise drop a taken beat
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    res_hit_reg <= (func_reg == FUNC_LOOKUP) && hit_any;
                    res_pay_reg <= (func_reg == FUNC_LOOKUP) ? hit_pay : '0;
                    if (upd_cmd == CMD_INS)
                        count_reg <= count_reg + CW'(1);
                    state_reg <= ST_EVICT;
                end
                ST_EVICT:
                begin
                    if (over)
                        count_reg <= count_reg - CW'(1);
                    else if (out_free)
                    begin
                        hit_reg          <= res_hit_reg;
                        read_payload_reg <= DATA_PORT_WIDTH'(res_pay_reg);
                        entry_count_reg  <= count_ext[COUNT_PORT_WIDTH-1:0];
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign read_payload = read_payload_reg;
    assign entry_count  = entry_count_reg;

endmodule

FILE: rtl/skst_cell.sv
module skst_cell
    import skst_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic [KEY_WIDTH-1:0]     key_cmp,
    input  logic [PAYLOAD_WIDTH-1:0] pay_new,
    input  logic [KEY_WIDTH-1:0]     key_below,
    input  logic [PAYLOAD_WIDTH-1:0] pay_below,
    input  logic                     lt_below,
    input  logic [KEY_WIDTH-1:0]     key_above,
    input  logic [PAYLOAD_WIDTH-1:0] pay_above,
    input  logic                     lt_above,
    output logic [KEY_WIDTH-1:0]     key_out,
    output logic [PAYLOAD_WIDTH-1:0] pay_out,
    output cell_stat_t               stat,
    output logic [PAYLOAD_WIDTH-1:0] sel_pay
);

    logic [KEY_WIDTH-1:0]     key_reg;
    logic [KEY_WIDTH-1:0]     key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_next;
    cell_stat_t               stat_reg;
    cell_stat_t               stat_next;
    logic [PAYLOAD_WIDTH-1:0] sel_pay_reg;
    logic [PAYLOAD_WIDTH-1:0] sel_pay_next;

    // Compare the held key against the item key
    always_comb
    begin
        stat_next.lt = ctrl.occupied && (key_reg < key_cmp);
        stat_next.eq = ctrl.occupied && (key_reg == key_cmp);
        sel_pay_next = stat_next.eq ? pay_reg : '0;
    end

    // Pick the next contents from self, neighbors or the new entry
    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        case (ctrl.cmd)
            CMD_INS:
            begin
                if (!stat_reg.lt)
                begin
                    if (lt_below)
                    begin
                        key_next = key_cmp;
                        pay_next = pay_new;
                    end
                    else
                    begin
                        key_next = key_below;
                        pay_next = pay_below;
                    end
                end
            end
            CMD_INSF:
            begin
                if (lt_above)
                begin
                    key_next = key_above;
                    pay_next = pay_above;
                end
                else if (stat_reg.lt)
                begin
                    key_next = key_cmp;
                    pay_next = pay_new;
                end
            end
            CMD_OVR:
            begin
                if (stat_reg.eq)
                    pay_next = pay_new;
            end
            CMD_SHIFT:
            begin
                key_next = key_above;
                pay_next = pay_above;
            end
            default:
            begin
                key_next = key_reg;
                pay_next = pay_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    // Register compare results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg    <= '0;
            sel_pay_reg <= '0;
        end
        else
        begin
            stat_reg    <= stat_next;
            sel_pay_reg <= sel_pay_next;
        end
    end

    assign key_out = key_reg;
    assign pay_out = pay_reg;
    assign stat    = stat_reg;
    assign sel_pay = sel_pay_reg;

endmodule

FILE: rtl/skst_checker.sv
`include "sorted_keyed_snapshot_table_defines.svh"

module skst_checker
    import skst_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        hit,
    input logic [DATA_PORT_WIDTH-1:0]  read_payload,
    input logic [COUNT_PORT_WIDTH-1:0] entry_count
);

    // A miss or a save carries a zero payload
    `SKST_ASSERT_IMP(a_miss_zero, out_valid && !hit, read_payload == '0, "payload on a miss")

    // The table never reports more entries than it has cells
    `SKST_ASSERT_IMP(a_count_bound, out_valid, 32'(entry_count) <= DEPTH, "entry count over depth")

    // One item at a time: busy right after a beat is taken
    `SKST_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "accepted while busy")

    // A stalled result stays valid
    `SKST_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

endmodule

bind sorted_keyed_snapshot_table skst_checker #(
    .DEPTH (DEPTH)
) u_skst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .read_payload (read_payload),
    .entry_count  (entry_count)
);
